[rtl/core/sorted_array_list_unit_assert.svh]
// ----------------------------------------------------------------------------
// Sorted array list assertion macros
// Shared concurrent assertion forms for the sorted array list unit.
// ----------------------------------------------------------------------------
`ifndef SORTED_ARRAY_LIST_UNIT_ASSERT_SVH
`define SORTED_ARRAY_LIST_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside of reset.
`define SAL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted array list check failed");

// Next-cycle implication, checked outside of reset.
`define SAL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted array list check failed");

`endif

[rtl/core/sal_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted array list package
// Operation and status codes, cell commands and the structs between cells.
// ----------------------------------------------------------------------------
package sal_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned POS_W   = 4;
    localparam int unsigned OP_W    = 3;
    localparam int unsigned COUNT_W = 5;

    // Request operation codes.
    typedef enum logic [OP_W-1:0] {
        OP_INSERT       = 3'd0,
        OP_REMOVE_VALUE = 3'd1,
        OP_REMOVE_AT    = 3'd2,
        OP_READ         = 3'd3,
        OP_CLEAR        = 3'd4
    } t_op;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_BAD_POS   = 2'd3
    } t_status;

    // Command broadcast to every cell of the row.
    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_INSERT,
        CMD_DEL_VALUE,
        CMD_DEL_POS,
        CMD_CLEAR
    } t_cmd;

    typedef struct packed {
        t_cmd               cmd;
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   pos;
    } t_cell_ctrl;

    // What a cell shows its neighbors and the row control.
    typedef struct packed {
        logic [VALUE_W-1:0] val;
        logic               occ;
        logic               shift_up;   // empty or holds a value above the key
        logic               del_from;   // empty or holds a value not below the key
        logic               match;      // holds a value equal to the key
    } t_cell_out;

endpackage

[rtl/core/sorted_array_list_unit.sv]
// ----------------------------------------------------------------------------
// Sorted array list unit
// Bounded ascending list of signed values built as a row of shifting cells.
// ----------------------------------------------------------------------------
// When a transaction is accepted, every cell compares its value with the
// request and the whole row inserts, closes a gap or clears in one step;
// then, in the evaluation state and once the output register is free, the
// read value and the largest entry are selected from the updated row into
// the output register. A new request is accepted only after that output
// register has been loaded, so requests do not overlap. Only positions 0
// to 15 can be addressed by read and remove-at requests.
`include "sorted_array_list_unit_assert.svh"

module sorted_array_list_unit #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request channel.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // value[31:0], position[35:32], zero[39:36]
    input  logic [2:0]  s_axis_tuser,   // operation[2:0]
    // Result channel.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // read_value[31:0], count[36:32],
                                        // largest_value[68:37], largest_valid[69],
                                        // zero[71:70]
    output logic [1:0]  m_axis_tuser    // status[1:0]
);
    import sal_pkg::*;

    localparam int unsigned CW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EVAL = 2'b10
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    t_status            r_status;
    t_status            n_status;
    logic               r_is_read;
    logic [POS_W-1:0]   r_pos;

    logic               r_out_valid;
    t_status            r_out_status;
    logic [VALUE_W-1:0] r_out_read;
    logic [COUNT_W-1:0] r_out_count;
    logic [VALUE_W-1:0] r_out_largest;
    logic               r_out_lvalid;

    logic               w_accept;
    logic               w_load;
    logic [OP_W-1:0]    w_op;
    logic [POS_W-1:0]   w_pos;
    logic               w_full;
    logic               w_found;
    logic               w_pos_ok;
    t_cell_ctrl         w_ctrl;
    t_cell_out          w_cell [CAPACITY];
    logic [CAPACITY-1:0] w_occ;
    logic [CAPACITY-1:0] w_match;
    logic [CAPACITY-1:0] w_last;
    logic [VALUE_W-1:0] w_largest;
    logic [VALUE_W-1:0] w_read;

    // Request fields.
    assign w_op     = s_axis_tuser;
    assign w_pos    = s_axis_tdata[35:32];
    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);

    // Row of cells.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_cell_out w_left;
        t_cell_out w_right;

        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_left
            assign w_left = w_cell[g-1];
        end

        if (g == CAPACITY - 1) begin : g_end
            assign w_right  = '0;
            assign w_last[g] = w_cell[g].occ;
        end else begin : g_right
            assign w_right  = w_cell[g+1];
            assign w_last[g] = w_cell[g].occ && !w_cell[g+1].occ;
        end

        assign w_occ[g]   = w_cell[g].occ;
        assign w_match[g] = w_cell[g].match;

        sal_cell #(
            .INDEX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_left  (w_left),
            .i_right (w_right),
            .o_cell  (w_cell[g])
        );
    end

    // Request checks against the current row.
    assign w_full   = (r_count == CW'(CAPACITY));
    assign w_found  = |w_match;
    assign w_pos_ok = int'(w_pos) < int'(r_count);

    // Command decode, count update and status.
    always_comb begin
        w_ctrl.cmd   = CMD_NONE;
        w_ctrl.value = s_axis_tdata[31:0];
        w_ctrl.pos   = w_pos;
        n_count      = r_count;
        n_status     = ST_DONE;
        unique case (t_op'(w_op))
            OP_INSERT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_ctrl.cmd = CMD_INSERT;
                    n_count    = r_count + CW'(1);
                end
            end
            OP_REMOVE_VALUE: begin
                if (w_found) begin
                    w_ctrl.cmd = CMD_DEL_VALUE;
                    n_count    = r_count - CW'(1);
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            OP_REMOVE_AT: begin
                if (w_pos_ok) begin
                    w_ctrl.cmd = CMD_DEL_POS;
                    n_count    = r_count - CW'(1);
                end else begin
                    n_status = ST_BAD_POS;
                end
            end
            OP_READ: begin
                if (!w_pos_ok) begin
                    n_status = ST_BAD_POS;
                end
            end
            OP_CLEAR: begin
                w_ctrl.cmd = CMD_CLEAR;
                n_count    = '0;
            end
            default: begin
            end
        endcase
        if (!w_accept) begin
            w_ctrl.cmd = CMD_NONE;
            n_count    = r_count;
        end
    end

    // Largest entry and read value, picked from the updated row.
    always_comb begin
        w_largest = '0;
        w_read    = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_largest = w_largest | ({VALUE_W{w_last[i]}} & w_cell[i].val);
            if ((i < (1 << POS_W)) && (int'(r_pos) == i)) begin
                w_read = w_cell[i].val;
            end
        end
    end

    // Sequencer.
    assign w_load = (r_state == S_EVAL) && (!r_out_valid || m_axis_tready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Per-request data carried into the selection cycle, and result payload.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status  <= n_status;
            r_is_read <= (w_op == OP_READ);
            r_pos     <= w_pos;
        end
        if (w_load) begin
            r_out_status  <= r_status;
            r_out_read    <= (r_is_read && (r_status == ST_DONE)) ? w_read : '0;
            r_out_count   <= COUNT_W'(r_count);
            r_out_largest <= w_largest;
            r_out_lvalid  <= (r_count != '0);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {2'b00, r_out_lvalid, r_out_largest, r_out_count, r_out_read};

    // Consistency of the count register with the cell row.
    `SAL_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY))
    `SAL_ASSERT_NOW(a_count_occ, i_clk, i_rst_n, 1'b1, $countones(w_occ) == int'(r_count))
    `SAL_ASSERT_NOW(a_occ_prefix, i_clk, i_rst_n, 1'b1, (w_occ & (w_occ + 1'b1)) == '0)
    `SAL_ASSERT_NEXT(a_accept_eval, i_clk, i_rst_n, w_accept, r_state == S_EVAL)

endmodule

[rtl/core/sal_cell.sv]
// ----------------------------------------------------------------------------
// Sorted array list cell
// One list slot: holds a value and an occupied flag, compares it with the
// broadcast key and moves data to or from its neighbors on a command.
// ----------------------------------------------------------------------------
module sal_cell #(
    parameter int unsigned INDEX = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sal_pkg::t_cell_ctrl i_ctrl,
    input  sal_pkg::t_cell_out  i_left,
    input  sal_pkg::t_cell_out  i_right,
    output sal_pkg::t_cell_out  o_cell
);
    import sal_pkg::*;

    logic [VALUE_W-1:0] r_val;
    logic [VALUE_W-1:0] n_val;
    logic               r_occ;
    logic               n_occ;
    logic               w_key_lt;
    logic               w_val_lt;
    logic               w_at_pos;

    // Signed compares against the broadcast key.
    assign w_key_lt = $signed(i_ctrl.value) < $signed(r_val);
    assign w_val_lt = $signed(r_val) < $signed(i_ctrl.value);
    assign w_at_pos = INDEX >= int'(i_ctrl.pos);

    assign o_cell.val      = r_val;
    assign o_cell.occ      = r_occ;
    assign o_cell.shift_up = !r_occ || w_key_lt;
    assign o_cell.del_from = !r_occ || !w_val_lt;
    assign o_cell.match    = r_occ && (r_val == i_ctrl.value);

    // Next slot contents for each command.
    always_comb begin
        n_val = r_val;
        n_occ = r_occ;
        unique case (i_ctrl.cmd)
            CMD_INSERT: begin
                if (i_left.shift_up) begin
                    n_val = i_left.val;
                    n_occ = i_left.occ;
                end else if (o_cell.shift_up) begin
                    n_val = i_ctrl.value;
                    n_occ = 1'b1;
                end
            end
            CMD_DEL_VALUE: begin
                if (o_cell.del_from) begin
                    n_val = i_right.val;
                    n_occ = i_right.occ;
                end
            end
            CMD_DEL_POS: begin
                if (w_at_pos) begin
                    n_val = i_right.val;
                    n_occ = i_right.occ;
                end
            end
            CMD_CLEAR: begin
                n_occ = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule
